@@ hdl/mtf_pkg.sv @@
// Package for the move-to-front recency list: sizes, state type.
`timescale 1ns / 1ps
`default_nettype none

package mtf_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int ADDR_W     = $clog2(LIST_DEPTH);
    localparam int POS_W      = $clog2(LIST_DEPTH + 1);
    localparam int INDEX_W    = 8;
    localparam int RANK_W     = 5;
    localparam int HITPOS_W   = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RANK_WAIT,
        ST_SEARCH,
        ST_SHIFT,
        ST_FRONT,
        ST_DONE
    } mtf_state_t;

endpackage

`default_nettype wire

@@ hdl/mtf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

@@ hdl/move_to_front_recent_list.sv @@
// Top level of the move-to-front recency list of palette indices.
//
// The block keeps a list of recently used palette indices, position 0 being
// the most recent. Each request on the slave channel either selects a colour
// index directly (s_tuser low) or selects the entry a given rank from the end
// of the list (s_tuser high). The selected index is moved to the front and
// one result is delivered on the master channel: the index, a hit flag and
// the position where it was found (the list depth on a miss).
// The list lives in a small RAM; one sequencer walks it one entry a cycle,
// first searching from the end towards the front, then moving entries up.
// Both walks share the single RAM read port. A rank request first reads the
// ranked entry from the RAM, in the ST_RANK_WAIT state, before the search.
// s_tready is high only while the sequencer is idle, so one request is in
// flight at a time and the next is taken once the sequencer has stored a
// result and returned to idle.
// The result is held in an output register; a stalled receiver keeps it
// there, and the block may take and work on the next request meanwhile,
// waiting only when that request's result is ready to be stored.
// After reset (aresetn low, synchronous) the whole list reads as zero at
// once, through per-entry valid flags, and no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module move_to_front_recent_list
    import mtf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] color_index, [12:8] recent_rank
    input  wire logic [0:0]  s_tuser,   // [0] func
    // Result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata    // [7:0] selected_index, [8] hit,
                                        // [14:9] hit_position
);

    mtf_state_t           state_reg, state_next;
    logic [INDEX_W-1:0]   value_reg, value_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;       // next address to read
    logic                 more_reg, more_next;       // reads left to issue
    logic [ADDR_W-1:0]    cmp_addr_reg, cmp_addr_next; // address of rd data
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 found_reg, found_next;
    logic [LIST_DEPTH-1:0] valid_reg;
    logic                 rd_valid_reg;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [INDEX_W-1:0]   out_index_reg, out_index_next;
    logic                 out_hit_reg, out_hit_next;
    logic [HITPOS_W-1:0]  out_pos_reg, out_pos_next;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [INDEX_W-1:0]   wr_data;
    logic [ADDR_W-1:0]    rd_addr;
    logic [INDEX_W-1:0]   ram_q;
    logic [INDEX_W-1:0]   entry;

    logic                 in_accept;
    logic [INDEX_W-1:0]   in_color;
    logic [RANK_W-1:0]    in_rank;
    logic [ADDR_W-1:0]    rank_addr;
    logic [ADDR_W-1:0]    shift_top;

    assign in_color  = s_tdata[INDEX_W-1:0];
    assign in_rank   = s_tdata[INDEX_W+RANK_W-1:INDEX_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // Entries never written since reset read as zero.
    assign entry = rd_valid_reg ? ram_q : '0;

    // A rank beyond the list end saturates to the front entry.
    always_comb begin
        if (int'(in_rank) >= LIST_DEPTH) begin
            rank_addr = '0;
        end else begin
            rank_addr = ADDR_W'(LIST_DEPTH - 1 - int'(in_rank));
        end
    end

    mtf_ram #(
        .WIDTH (INDEX_W),
        .DEPTH (LIST_DEPTH)
    ) u_list_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            more_reg     <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            more_reg     <= more_next;
            cmp_vld_reg  <= cmp_vld_next;
            rd_valid_reg <= valid_reg[rd_addr];
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
        value_reg     <= value_next;
        addr_reg      <= addr_next;
        cmp_addr_reg  <= cmp_addr_next;
        pos_reg       <= pos_next;
        found_reg     <= found_next;
        out_index_reg <= out_index_next;
        out_hit_reg   <= out_hit_next;
        out_pos_reg   <= out_pos_next;
    end

    always_comb begin
        state_next     = state_reg;
        value_next     = value_reg;
        addr_next      = addr_reg;
        more_next      = more_reg;
        cmp_addr_next  = cmp_addr_reg;
        cmp_vld_next   = 1'b0;
        pos_next       = pos_reg;
        found_next     = found_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_index_next = out_index_reg;
        out_hit_next   = out_hit_reg;
        out_pos_next   = out_pos_reg;
        rd_addr        = addr_reg;
        wr_en          = 1'b0;
        wr_addr        = cmp_addr_reg + 1'b1;
        wr_data        = entry;
        shift_top      = found_reg ? pos_reg[ADDR_W-1:0] : ADDR_W'(LIST_DEPTH - 1);

        case (state_reg)
            ST_IDLE: begin
                rd_addr = rank_addr;
                if (in_accept) begin
                    value_next = in_color;
                    addr_next  = ADDR_W'(LIST_DEPTH - 1);
                    more_next  = 1'b1;
                    found_next = 1'b0;
                    pos_next   = POS_W'(LIST_DEPTH);
                    state_next = s_tuser[0] ? ST_RANK_WAIT : ST_SEARCH;
                end
            end

            ST_RANK_WAIT: begin
                value_next = entry;
                state_next = ST_SEARCH;
            end

            ST_SEARCH: begin
                // Issue reads from the list end down; compare each in the following cycle.
                if (more_reg) begin
                    cmp_addr_next = addr_reg;
                    cmp_vld_next  = 1'b1;
                    addr_next     = addr_reg - 1'b1;
                    more_next     = (addr_reg != '0);
                end
                if (cmp_vld_reg && (entry == value_reg)) begin
                    found_next = 1'b1;
                    pos_next   = POS_W'(cmp_addr_reg);
                    shift_top  = cmp_addr_reg;
                end
                if (cmp_vld_reg && ((entry == value_reg) || (cmp_addr_reg == '0))) begin
                    addr_next    = shift_top - 1'b1;
                    more_next    = (shift_top != '0);
                    cmp_vld_next = 1'b0;
                    state_next   = ST_SHIFT;
                end
            end

            ST_SHIFT: begin
                // Entry read last cycle is written one place further back.
                if (more_reg) begin
                    cmp_addr_next = addr_reg;
                    cmp_vld_next  = 1'b1;
                    addr_next     = addr_reg - 1'b1;
                    more_next     = (addr_reg != '0);
                end
                if (cmp_vld_reg) begin
                    wr_en = 1'b1;
                end
                if (!more_reg && (!cmp_vld_reg || (cmp_addr_reg == '0))) begin
                    cmp_vld_next = 1'b0;
                    state_next   = ST_FRONT;
                end
            end

            ST_FRONT: begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = value_reg;
                state_next = ST_DONE;
            end

            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next  = 1'b1;
                    out_index_next = value_reg;
                    out_hit_next   = found_reg;
                    out_pos_next   = HITPOS_W'(pos_reg);
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_pos_reg, out_hit_reg, out_index_reg};

endmodule

`default_nettype wire
